[design/csl_pkg.sv]
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types and constants for the cache set LRU controller.
// ----------------------------------------------------------------------------
package csl_pkg;

	localparam int WAYS        = 4;
	localparam int TAG_BITS    = 20;
	localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FIELD_TAG_W = 20;
	localparam int FIELD_WAY_W = 2;

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	typedef logic [TAG_BITS-1:0] stag_t;
	typedef logic [WAY_W-1:0]    way_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} ctl_state_t;

	typedef struct packed {
		logic                   en;
		way_idx_t               addr;
		stag_t                  data;
	} tag_wr_t;

	typedef struct packed {
		logic [FIELD_TAG_W-1:0] tag;
		logic                   mode;
	} req_t;

	typedef struct packed {
		logic                   hit;
		logic [FIELD_WAY_W-1:0] way;
		logic                   fill;
		logic                   writeback;
		logic [FIELD_TAG_W-1:0] victim_tag;
	} rsp_t;

endpackage

[design/csl_tag_store.sv]
// ----------------------------------------------------------------------------
// csl_tag_store
// Per-way tag memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module csl_tag_store (
	input  logic              clk,
	input  csl_pkg::way_idx_t rd_addr,
	input  csl_pkg::tag_wr_t  wr,
	output csl_pkg::stag_t    rd_data
);
	import csl_pkg::*;

	stag_t tag_mem [WAYS];
	stag_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			tag_mem[wr.addr] <= wr.data;
		end
		rd_data_q <= tag_mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[design/cache_set_lru_controller.sv]
// ----------------------------------------------------------------------------
// cache_set_lru_controller
// Tag and LRU replacement control for one write-back set-associative set.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low. The transfer cycle
// launches the first tag read, the tag memory is then read a way at a time
// through its single read port, and a final step decides and updates valid,
// dirty, recency and the tag memory. busy goes high after the transfer and
// stays high until that step ends; the result appears on result with done high
// for exactly one cycle right after, which is also the first cycle a new
// access can be taken. The receiver cannot hold the result off.
// ----------------------------------------------------------------------------
module cache_set_lru_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  csl_pkg::req_t access,
	output logic          done,
	output csl_pkg::rsp_t result
);
	import csl_pkg::*;

	ctl_state_t state_q, state_d;
	stag_t      tag_q;
	logic       mode_q;
	way_idx_t   scan_q;
	logic       found_q;
	way_idx_t   hit_way_q;
	stag_t      vtag_q;
	logic       valid_q [WAYS];
	logic       dirty_q [WAYS];
	way_idx_t   rank_q  [WAYS];
	logic       done_q;
	rsp_t       result_q;

	way_idx_t   rd_addr;
	stag_t      rd_data;
	tag_wr_t    tag_wr;

	way_idx_t   victim_way;
	way_idx_t   first_inv;
	logic       any_invalid;
	way_idx_t   chosen;
	way_idx_t   old_rank;
	logic       wb;
	logic       match;
	logic       last_way;

	csl_tag_store u_tag_store (
		.clk     (clk),
		.rd_addr (rd_addr),
		.wr      (tag_wr),
		.rd_data (rd_data)
	);

	always_comb begin
		victim_way  = '0;
		first_inv   = '0;
		any_invalid = 1'b0;
		for (int i = 1; i < WAYS; i++) begin
			if (rank_q[i] > rank_q[victim_way]) begin
				victim_way = WAY_W'(i);
			end
		end
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				first_inv   = WAY_W'(i);
				any_invalid = 1'b1;
			end
		end
	end

	always_comb begin
		if (found_q) begin
			chosen = hit_way_q;
		end else if (any_invalid) begin
			chosen = first_inv;
		end else begin
			chosen = victim_way;
		end
		old_rank = (!found_q && any_invalid) ? WAY_W'(WAYS - 1) : rank_q[chosen];
		wb       = !found_q && !any_invalid && dirty_q[victim_way];
		match    = valid_q[scan_q] && (rd_data == tag_q);
		last_way = (scan_q == WAY_W'(WAYS - 1));
	end

	always_comb begin
		state_d     = state_q;
		rd_addr     = '0;
		busy        = (state_q != ST_IDLE);
		tag_wr.en   = 1'b0;
		tag_wr.addr = chosen;
		tag_wr.data = tag_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_addr = WAY_W'(scan_q + 1'b1);
				if (last_way) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				tag_wr.en = !found_q;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			done_q  <= 1'b0;
			for (int i = 0; i < WAYS; i++) begin
				valid_q[i] <= 1'b0;
				dirty_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else begin
			done_q <= (state_q == ST_FIN);
			if (state_q == ST_IDLE && start) begin
				found_q <= 1'b0;
			end
			if (state_q == ST_SCAN && match && !found_q) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_FIN) begin
				for (int i = 0; i < WAYS; i++) begin
					if (WAY_W'(i) != chosen && valid_q[i] && rank_q[i] < old_rank
					    && rank_q[i] != WAY_W'(WAYS - 1)) begin
						rank_q[i] <= WAY_W'(rank_q[i] + 1'b1);
					end
				end
				rank_q[chosen] <= '0;
				if (found_q) begin
					dirty_q[chosen] <= dirty_q[chosen] | (mode_q == MODE_WRITE);
				end else begin
					valid_q[chosen] <= 1'b1;
					dirty_q[chosen] <= (mode_q == MODE_WRITE);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			tag_q  <= access.tag[TAG_BITS-1:0];
			mode_q <= access.mode;
			scan_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			scan_q <= WAY_W'(scan_q + 1'b1);
			if (match && !found_q) begin
				hit_way_q <= scan_q;
			end
			if (scan_q == victim_way) begin
				vtag_q <= rd_data;
			end
		end
		if (state_q == ST_FIN) begin
			result_q.hit        <= found_q;
			result_q.way        <= FIELD_WAY_W'(chosen);
			result_q.fill       <= !found_q;
			result_q.writeback  <= wb;
			result_q.victim_tag <= wb ? FIELD_TAG_W'(vtag_q) : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[tb/tb_cache_set_lru_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cache_set_lru_controller
// Self-checking bench for the cache set LRU controller: a shadow copy of the
// set (tags, valid, dirty, recency) predicts hit, way, fill, writeback and victim tag for
// each access, directed corner accesses come first, then random accesses
// drawn mostly from a small tag pool so hits, fills and evictions all recur.
// ----------------------------------------------------------------------------

import csl_pkg::*;

class set_lru_tracker;

	stag_t       way_tag   [WAYS];
	bit          way_live  [WAYS];
	bit          way_dirty [WAYS];
	int unsigned way_age   [WAYS];
	rsp_t        due_q[$];
	int unsigned mismatches;

	function new();
		for (int i = 0; i < WAYS; i++) begin
			way_tag[i]   = '0;
			way_live[i]  = 1'b0;
			way_dirty[i] = 1'b0;
			way_age[i]   = 0;
		end
		mismatches = 0;
	endfunction

	function void promote(int w, int unsigned old_age);
		for (int i = 0; i < WAYS; i++) begin
			if (i != w && way_live[i] && way_age[i] < old_age && way_age[i] < WAYS - 1)
				way_age[i]++;
		end
		way_age[w] = 0;
	endfunction

	function void log_access(req_t item);
		stag_t t;
		bit    wr;
		bit    found;
		bit    empty;
		int    pick;
		rsp_t  r;
		t     = item.tag[TAG_BITS-1:0];
		wr    = (item.mode == MODE_WRITE);
		found = 1'b0;
		empty = 1'b0;
		pick  = 0;
		r     = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (!found && way_live[i] && way_tag[i] == t) begin
				pick  = i;
				found = 1'b1;
			end
		end
		if (found) begin
			if (wr)
				way_dirty[pick] = 1'b1;
			promote(pick, way_age[pick]);
		end else begin
			for (int i = 0; i < WAYS; i++) begin
				if (!empty && !way_live[i]) begin
					pick  = i;
					empty = 1'b1;
				end
			end
			if (empty) begin
				promote(pick, WAYS - 1);
			end else begin
				pick = 0;
				for (int i = 1; i < WAYS; i++) begin
					if (way_age[i] > way_age[pick])
						pick = i;
				end
				if (way_dirty[pick]) begin
					r.writeback  = 1'b1;
					r.victim_tag = FIELD_TAG_W'(way_tag[pick]);
				end
				promote(pick, way_age[pick]);
			end
			way_tag[pick]   = t;
			way_live[pick]  = 1'b1;
			way_dirty[pick] = wr;
		end
		r.hit  = found;
		r.way  = FIELD_WAY_W'(pick);
		r.fill = !found;
		due_q.push_back(r);
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	task check_response(rsp_t got);
		rsp_t want;
		if (due_q.size() == 0) begin
			report("result with no access pending", 64'(got), 64'(0));
			return;
		end
		want = due_q.pop_front();
		if (got.hit !== want.hit)
			report("hit", 64'(got.hit), 64'(want.hit));
		if (got.way !== want.way)
			report("way", 64'(got.way), 64'(want.way));
		if (got.fill !== want.fill)
			report("fill", 64'(got.fill), 64'(want.fill));
		if (got.writeback !== want.writeback)
			report("writeback", 64'(got.writeback), 64'(want.writeback));
		if (got.victim_tag !== want.victim_tag)
			report("victim_tag", 64'(got.victim_tag), 64'(want.victim_tag));
	endtask

	function int pending();
		return due_q.size();
	endfunction

endclass

module tb_cache_set_lru_controller;

	localparam int RANDOM_ACCESSES = 1850;
	localparam int STALL_LIMIT     = 200;
	localparam int DRAIN_CYCLES    = 12;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t access;
	logic done;
	rsp_t result;

	set_lru_tracker tracker;

	cache_set_lru_controller uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.access (access),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_response(result);
	end

	// call at a falling edge; returns at the falling edge after the transfer
	task automatic issue_access(input stag_t t, input logic m, input int gap);
		req_t item;
		item.tag  = FIELD_TAG_W'(t);
		item.mode = m;
		start = 1'b0;
		while (busy)
			@(negedge clk);
		repeat (gap) @(negedge clk);
		start  = 1'b1;
		access = item;
		do begin
			@(posedge clk);
		end while (busy);
		tracker.log_access(item);
		@(negedge clk);
	endtask

	initial begin : watchdog
		int unsigned stall;
		stall = 0;
		@(posedge arst_n);
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				stall = 0;
			else
				stall++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		stag_t pool [8];
		int    span;
		bit    eager;
		stag_t t;
		int    gap;
		tracker = new();
		arst_n  = 1'b0;
		start   = 1'b0;
		access  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill empty ways, hit, dirty a way, then evict clean and dirty victims
		issue_access(20'h00000, MODE_READ,  $urandom_range(0, 6));
		issue_access(20'hFFFFF, MODE_WRITE, $urandom_range(0, 6));
		issue_access(20'h00000, MODE_READ,  $urandom_range(0, 6));
		issue_access(20'h00000, MODE_WRITE, $urandom_range(0, 6));
		issue_access(20'h5A5A5, MODE_READ,  $urandom_range(0, 6));
		issue_access(20'hA5A5A, MODE_WRITE, $urandom_range(0, 6));
		issue_access(20'hFFFFF, MODE_READ,  $urandom_range(0, 6));
		issue_access(20'h12345, MODE_READ,  $urandom_range(0, 6));
		issue_access(20'h80000, MODE_READ,  $urandom_range(0, 6));
		issue_access(20'h00001, MODE_WRITE, $urandom_range(0, 6));
		issue_access(20'hFFFFF, MODE_WRITE, $urandom_range(0, 6));
		issue_access(20'h12345, MODE_READ,  0);
		issue_access(20'h7FFFF, MODE_WRITE, 0);
		issue_access(20'hEDCBA, MODE_READ,  0);
		issue_access(20'h00001, MODE_READ,  $urandom_range(0, 6));
		issue_access(20'h00002, MODE_WRITE, $urandom_range(0, 6));
		issue_access(20'h00004, MODE_READ,  $urandom_range(0, 6));
		issue_access(20'h7FFFF, MODE_READ,  $urandom_range(0, 6));
		issue_access(20'h00008, MODE_READ,  $urandom_range(0, 6));
		issue_access(20'hEDCBA, MODE_WRITE, $urandom_range(0, 6));
		issue_access(20'h00010, MODE_WRITE, $urandom_range(0, 6));

		for (int k = 0; k < 8; k++)
			pool[k] = stag_t'($urandom());
		span  = 6;
		eager = 1'b0;
		for (int n = 0; n < RANDOM_ACCESSES; n++) begin
			if (n % 64 == 0) begin
				span  = $urandom_range(3, 8);
				eager = ($urandom_range(0, 2) == 0);
			end
			if (n % 40 == 0)
				pool[$urandom_range(0, 7)] = stag_t'($urandom());
			if ($urandom_range(0, 99) < 85)
				t = pool[$urandom_range(0, span - 1)];
			else
				t = stag_t'($urandom());
			gap = eager ? 0 : $urandom_range(0, 6);
			issue_access(t, logic'($urandom_range(0, 1)), gap);
		end
		start = 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
